### rtl/core/asg_pkg.sv
package asg_pkg;

    localparam int NUM_CHANNELS_DEF = 11;
    localparam int NUM_RAMPED_DEF   = 4;
    localparam int NUM_KILLED_DEF   = 5;

    localparam logic signed [15:0] CMD_LIMIT  = 16'sd9600;
    localparam logic [15:0]        STEP_RESET = 16'd2560;
    localparam logic [17:0]        SWEEP_EL_MAX = 18'h3FFFF;
    localparam logic [16:0]        MOTOR_EL_MAX = 17'h1FFFF;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_SWEEP  = 3'd1;
    localparam logic [2:0] OP_MOTOR  = 3'd2;
    localparam logic [2:0] OP_SLIDER = 3'd3;
    localparam logic [2:0] OP_MSLIDE = 3'd4;

    localparam logic [1:0] REG_CHANNEL = 2'd0;
    localparam logic [1:0] REG_MIN     = 2'd1;
    localparam logic [1:0] REG_MAX     = 2'd2;
    localparam logic [1:0] REG_STEP    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HANDLER,
        ST_RD_SWEEP,
        ST_WAIT_SWEEP,
        ST_CHAN_RD,
        ST_CHAN_DATA,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [35:0] dividend;   // magnitude
        logic [16:0] divisor;
    } t_div_req;

endpackage

### rtl/core/asg_ram.sv
module asg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/asg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module asg_div
    import asg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [35:0] o_quot
);
    logic [35:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [17:0] w_trial;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        w_trial = {r_rem, r_q[35]} - {1'b0, r_den};
        if (i_req.start) begin
            n_q = i_req.dividend; n_rem = '0; n_den = i_req.divisor;
            n_cnt = 6'd36; n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[17]) begin
                n_rem = w_trial[16:0];
                n_q = {r_q[34:0], 1'b1};
            end else begin
                n_rem = {r_rem[15:0], r_q[35]};
                n_q = {r_q[34:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### rtl/core/actuator_sweep_generator.sv
// Actuator sweep generator. Config writes on i_cfg_* take effect at the next edge
// and should only be issued while the block is idle. A handler or write request
// holds o_ready low in the cycle after acceptance. A motor sweep start keeps
// o_ready low longer while the ramped sliders are rewritten. A tick request
// emits NUM_CHANNELS results, one per channel. A new request is taken only once
// the last result of a tick is registered; each swept or ramped channel passes
// through the serial divider, and a result that waits for i_ready holds up the
// next channel. After reset the slider memory is cleared entry by entry before
// the first request is taken.
module actuator_sweep_generator
    import asg_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int NUM_RAMPED   = NUM_RAMPED_DEF,
    parameter int NUM_KILLED   = NUM_KILLED_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_opcode,
    input  logic               i_activate,
    input  logic [3:0]         i_channel,
    input  logic signed [15:0] i_value,
    input  logic               i_motors_master_on,
    input  logic [4:0]         i_motor_enable_mask,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_out_channel,
    output logic signed [14:0] o_command,
    output logic               o_last
);
    localparam int AW = $clog2(NUM_CHANNELS);
    localparam int RW = (NUM_RAMPED > 1) ? $clog2(NUM_RAMPED) : 1;

    // config
    logic [3:0]         r_cfg_chan;
    logic signed [15:0] r_cfg_min, r_cfg_max;
    logic [15:0]        r_cfg_step;

    // sweep state
    logic r_sw_act, r_mo_act;
    logic [17:0] r_sw_el;
    logic [16:0] r_mo_el;
    logic [3:0]  r_cap_chan;
    logic signed [15:0] r_cap_min, r_cap_max, r_mslider, r_ramp_end;
    logic [15:0] r_cap_step, r_ramp_step;
    logic signed [15:0] r_ramp_begin [NUM_RAMPED];
    logic signed [14:0] r_last_out [NUM_RAMPED];

    // request capture
    logic [2:0]  r_op;
    logic        r_act, r_master;
    logic [4:0]  r_mask;
    logic [3:0]  r_ch;
    logic signed [15:0] r_val;

    t_state r_state, n_state;
    logic [AW:0] r_idx;
    logic signed [15:0] r_sw_slider;   // slider of swept channel
    logic signed [16:0] r_base;        // a of lerp
    logic               r_neg;
    logic signed [16:0] r_cmd;         // pre-clamp value
    logic               r_sw_do, r_mo_do; // interpolation enabled this tick

    logic r_oval;
    logic [3:0] r_ochan;
    logic signed [14:0] r_ocmd;
    logic r_olast;

    // motor slider fill
    logic r_mfill;
    logic [RW:0] r_mcnt;

    // memory
    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [15:0]     w_wdata, w_rdata;

    asg_ram #(.WIDTH(16), .DEPTH(NUM_CHANNELS)) u_slider (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    t_div_req    w_div;
    logic        w_div_done;
    logic [35:0] w_quot;

    asg_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_div),
        .o_done(w_div_done), .o_quot(w_quot)
    );

    logic w_acc;
    assign o_ready = (r_state == ST_IDLE) && !r_mfill;
    assign w_acc = i_valid && o_ready;

    logic [AW-1:0] w_idx;
    assign w_idx = r_idx[AW-1:0];

    // effective steps
    logic [16:0] w_sst, w_mst;
    assign w_sst = (r_cap_step == 16'd0) ? 17'd1 : {1'b0, r_cap_step};
    assign w_mst = (r_ramp_step == 16'd0) ? 17'd1 : {1'b0, r_ramp_step};

    // segment select for the sweep: k = el/st via compares against multiples
    logic [18:0] w_m1, w_m2, w_m3;
    logic [1:0]  w_k;
    logic [17:0] w_f;
    always_comb begin
        w_m1 = {2'b0, w_sst};
        w_m2 = {1'b0, w_sst, 1'b0};
        w_m3 = w_m1 + w_m2;
        if ({1'b0, r_sw_el} >= w_m3) begin
            w_k = 2'd3; w_f = 18'({1'b0, r_sw_el} - w_m3);
        end else if ({1'b0, r_sw_el} >= w_m2) begin
            w_k = 2'd2; w_f = 18'({1'b0, r_sw_el} - w_m2);
        end else if ({1'b0, r_sw_el} >= w_m1) begin
            w_k = 2'd1; w_f = 18'({1'b0, r_sw_el} - w_m1);
        end else begin
            w_k = 2'd0; w_f = r_sw_el;
        end
    end
    logic w_sw_end;
    assign w_sw_end = ({1'b0, r_sw_el} == {w_sst, 2'b00});

    logic w_is_sw, w_is_mo;
    assign w_is_sw = r_sw_do && !w_sw_end && ({1'b0, r_cap_chan} == 5'(r_idx));
    assign w_is_mo = r_mo_do && (r_idx < (AW+1)'(NUM_RAMPED));

    // lerp operands for current channel, from the captured sweep or ramp registers
    logic signed [16:0] w_a, w_b, w_d;
    logic [16:0] w_dmag;
    logic [33:0] w_prod;
    logic [16:0] w_num;
    always_comb begin
        w_a = '0; w_b = '0; w_num = '0;
        if (w_is_mo) begin
            w_a = 17'(r_ramp_begin[r_idx[RW-1:0]]);
            w_b = 17'(r_ramp_end);
            w_num = r_mo_el;
        end else begin
            unique case (w_k)
                2'd0: begin w_a = 17'(r_sw_slider); w_b = 17'(r_cap_min); end
                2'd1: begin w_a = 17'(r_cap_min); w_b = 17'(r_sw_slider); end
                2'd2: begin w_a = 17'(r_sw_slider); w_b = 17'(r_cap_max); end
                default: begin w_a = 17'(r_cap_max); w_b = 17'(r_sw_slider); end
            endcase
            w_num = w_f[16:0];
        end
        w_d = w_b - w_a;
        w_dmag = w_d[16] ? 17'(-w_d) : w_d;
        w_prod = w_dmag * w_num;
    end

    // kill and clamp
    logic signed [14:0] w_clamped;
    always_comb begin
        if ((r_idx < (AW+1)'(NUM_KILLED)) &&
            (!r_master || !(r_idx < 5 && r_mask[r_idx[2:0]]))) begin
            w_clamped = -15'sd9600;
        end else if (r_cmd > 17'(CMD_LIMIT)) begin
            w_clamped = 15'sd9600;
        end else if (r_cmd < -17'(CMD_LIMIT)) begin
            w_clamped = -15'sd9600;
        end else begin
            w_clamped = r_cmd[14:0];
        end
    end

    logic signed [37:0] w_qs;
    assign w_qs = r_neg ? -38'(w_quot) : 38'(w_quot);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_idx == (AW+1)'(NUM_CHANNELS - 1)) n_state = ST_IDLE;
            ST_IDLE: if (w_acc) begin
                if (i_opcode == OP_TICK) n_state = ST_RD_SWEEP;
                else n_state = ST_HANDLER;
            end
            ST_HANDLER: n_state = ST_IDLE;
            ST_RD_SWEEP: n_state = ST_WAIT_SWEEP;
            ST_WAIT_SWEEP: n_state = ST_CHAN_RD;
            ST_CHAN_RD: n_state = ST_CHAN_DATA;
            ST_CHAN_DATA: n_state = (w_is_sw || w_is_mo) ? ST_DIV : ST_EMIT;
            ST_DIV: if (w_div_done) n_state = ST_EMIT;
            ST_EMIT: if (!r_oval || i_ready) begin
                if (r_idx == (AW+1)'(NUM_CHANNELS - 1)) n_state = ST_IDLE;
                else n_state = ST_CHAN_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory port and divider control
    always_comb begin
        w_we = 1'b0; w_waddr = w_idx; w_wdata = '0; w_raddr = w_idx;
        w_div.start = 1'b0;
        w_div.dividend = 36'(w_prod);
        w_div.divisor = w_is_mo ? w_mst : w_sst;
        unique case (r_state)
            ST_CLEAR: w_we = 1'b1;
            ST_HANDLER: begin
                if (r_op == OP_SLIDER && r_ch < 4'(NUM_CHANNELS)) begin
                    w_we = 1'b1; w_waddr = r_ch[AW-1:0]; w_wdata = r_val;
                end
            end
            ST_RD_SWEEP: w_raddr = r_cap_chan[AW-1:0];
            ST_CHAN_DATA: w_div.start = w_is_sw || w_is_mo;
            default: ;
        endcase
        // fill runs only in idle with the input held off
        if (r_mfill) begin
            w_we = 1'b1; w_waddr = AW'(r_mcnt); w_wdata = r_ramp_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx <= '0;
            r_cfg_chan <= '0; r_cfg_min <= '0; r_cfg_max <= '0; r_cfg_step <= STEP_RESET;
            r_sw_act <= 1'b0; r_mo_act <= 1'b0;
            r_sw_el <= '0; r_mo_el <= '0;
            r_cap_chan <= '0; r_cap_min <= '0; r_cap_max <= '0; r_cap_step <= STEP_RESET;
            r_mslider <= '0; r_ramp_end <= '0; r_ramp_step <= STEP_RESET;
            for (int i = 0; i < NUM_RAMPED; i++) begin
                r_ramp_begin[i] <= '0;
                r_last_out[i] <= '0;
            end
            r_oval <= 1'b0;
            r_sw_do <= 1'b0; r_mo_do <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_CHANNEL: r_cfg_chan <= i_cfg_data[3:0];
                    REG_MIN:     r_cfg_min <= i_cfg_data;
                    REG_MAX:     r_cfg_max <= i_cfg_data;
                    default:     r_cfg_step <= i_cfg_data;
                endcase
            end
            if (r_oval && i_ready && r_state != ST_EMIT) r_oval <= 1'b0;
            unique case (r_state)
                ST_CLEAR: r_idx <= r_idx + 1'b1;
                ST_HANDLER: begin
                    if (r_op == OP_SWEEP) begin
                        if (!r_sw_act && !r_mo_act && r_act) begin
                            r_cap_chan <= r_cfg_chan; r_cap_min <= r_cfg_min;
                            r_cap_max <= r_cfg_max; r_cap_step <= r_cfg_step;
                            r_sw_act <= 1'b1; r_sw_el <= '0;
                        end else if (!r_act) begin
                            r_sw_act <= 1'b0;
                        end
                    end else if (r_op == OP_MOTOR) begin
                        r_sw_act <= 1'b0;
                        if (!r_mo_act && r_act) begin
                            for (int i = 0; i < NUM_RAMPED; i++)
                                r_ramp_begin[i] <= 16'(r_last_out[i]);
                            r_ramp_end <= r_mslider;
                            r_ramp_step <= r_cfg_step;
                            r_mo_el <= '0;
                            r_mo_act <= 1'b1;
                            r_idx <= '0;
                        end
                    end else if (r_op == OP_MSLIDE) begin
                        r_mslider <= r_val;
                    end
                end
                ST_RD_SWEEP: begin
                    r_sw_do <= r_sw_act && ({1'b0, r_sw_el} <= {w_sst, 2'b00});
                    r_mo_do <= r_mo_act && (r_mo_el <= w_mst);
                    if (r_sw_act && ({1'b0, r_sw_el} > {w_sst, 2'b00})) r_sw_act <= 1'b0;
                    if (r_mo_act && (r_mo_el > w_mst)) r_mo_act <= 1'b0;
                    r_idx <= '0;
                end
                ST_WAIT_SWEEP: r_sw_slider <= (r_cap_chan < 4'(NUM_CHANNELS)) ? w_rdata : '0;
                ST_CHAN_DATA: begin
                    r_base <= w_a;
                    r_neg <= w_d[16];
                    if (r_sw_do && w_sw_end && ({1'b0, r_cap_chan} == 5'(r_idx)))
                        r_cmd <= 17'(r_sw_slider);
                    else
                        r_cmd <= 17'($signed(w_rdata));
                end
                ST_DIV: if (w_div_done) r_cmd <= 17'(38'(r_base) + w_qs);
                ST_EMIT: if (!r_oval || i_ready) begin
                    r_oval <= 1'b1;
                    r_ochan <= 4'(r_idx);
                    r_ocmd <= w_clamped;
                    r_olast <= (r_idx == (AW+1)'(NUM_CHANNELS - 1));
                    if (r_idx < (AW+1)'(NUM_RAMPED)) r_last_out[r_idx[RW-1:0]] <= w_clamped;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == (AW+1)'(NUM_CHANNELS - 1)) begin
                        if (r_sw_do && r_sw_el < SWEEP_EL_MAX) r_sw_el <= r_sw_el + 1'b1;
                        if (r_mo_do && r_mo_el < MOTOR_EL_MAX) r_mo_el <= r_mo_el + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // motor handler also writes sliders 0..NUM_RAMPED-1; done one per cycle
    // on the write port after the handler cycle, input held off meanwhile
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mfill <= 1'b0;
            r_mcnt <= '0;
        end else if (r_state == ST_HANDLER && r_op == OP_MOTOR && !r_mo_act && r_act) begin
            r_mfill <= 1'b1;
            r_mcnt <= '0;
        end else if (r_mfill) begin
            r_mcnt <= r_mcnt + 1'b1;
            if (r_mcnt == (RW+1)'(NUM_RAMPED - 1)) r_mfill <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op <= i_opcode; r_act <= i_activate; r_ch <= i_channel;
            r_val <= i_value; r_master <= i_motors_master_on;
            r_mask <= i_motor_enable_mask;
        end
    end

    assign o_valid = r_oval;
    assign o_out_channel = r_ochan;
    assign o_command = r_ocmd;
    assign o_last = r_olast;
endmodule

### test/asg_checker.sv
module asg_checker
    import asg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_opcode,
    input  logic               i_activate,
    input  logic [3:0]         i_channel,
    input  logic signed [15:0] i_value,
    input  logic               i_motors_master_on,
    input  logic [4:0]         i_motor_enable_mask,
    input  logic               i_out_valid,
    input  logic               i_ready,
    input  logic [3:0]         i_out_channel,
    input  logic signed [14:0] i_command,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH  = NUM_CHANNELS_DEF;
    localparam int NRMP = NUM_RAMPED_DEF;
    localparam int NKIL = NUM_KILLED_DEF;
    localparam int LIM  = 9600;

    typedef struct {
        logic [3:0]         chan;
        logic signed [14:0] cmd;
        logic               last;
    } t_cmd_result;

    t_cmd_result expected_cmds[$];

    // configuration copy
    logic [3:0]  cfg_chan;
    int          cfg_min, cfg_max;
    int unsigned cfg_step;

    // predicted state
    int          sliders[NCH];
    int          motor_slider;
    int          last_motor[NRMP];
    bit          sweep_on, motor_on;
    int unsigned sweep_el, motor_el;
    logic [3:0]  cap_chan;
    int          cap_min, cap_max;
    int unsigned cap_step;
    int          ramp_from[NRMP];
    int          ramp_to;
    int unsigned ramp_len;

    function automatic int interp(int a, int b, int unsigned num, int unsigned den);
        longint d;
        d = longint'(b) - longint'(a);
        return a + int'((d * longint'(num)) / longint'(den));
    endfunction

    task automatic clear_model();
        cfg_chan = 0; cfg_min = 0; cfg_max = 0; cfg_step = STEP_RESET;
        foreach (sliders[i]) sliders[i] = 0;
        foreach (last_motor[i]) begin
            last_motor[i] = 0;
            ramp_from[i] = 0;
        end
        motor_slider = 0;
        sweep_on = 0; motor_on = 0; sweep_el = 0; motor_el = 0;
        cap_chan = 0; cap_min = 0; cap_max = 0; cap_step = STEP_RESET;
        ramp_to = 0; ramp_len = STEP_RESET;
    endtask

    task automatic predict_tick(bit master, logic [4:0] mask);
        int cmd[NCH];
        int unsigned st, k, f;
        int s, v;
        t_cmd_result r;
        foreach (cmd[i]) cmd[i] = sliders[i];
        if (sweep_on) begin
            st = (cap_step != 0) ? cap_step : 1;
            if (sweep_el > 4 * st) begin
                sweep_on = 0;
            end else begin
                k = sweep_el / st;
                f = sweep_el % st;
                s = (cap_chan < NCH) ? sliders[cap_chan] : 0;
                case (k)
                    0: v = interp(s, cap_min, f, st);
                    1: v = interp(cap_min, s, f, st);
                    2: v = interp(s, cap_max, f, st);
                    3: v = interp(cap_max, s, f, st);
                    default: v = s;
                endcase
                if (cap_chan < NCH) cmd[cap_chan] = v;
                if (sweep_el < SWEEP_EL_MAX) sweep_el++;
            end
        end
        if (motor_on) begin
            st = (ramp_len != 0) ? ramp_len : 1;
            if (motor_el > st) begin
                motor_on = 0;
            end else begin
                for (int i = 0; i < NRMP; i++) cmd[i] = interp(ramp_from[i], ramp_to, motor_el, st);
                if (motor_el < MOTOR_EL_MAX) motor_el++;
            end
        end
        for (int i = 0; i < NKIL; i++)
            if (!master || !mask[i]) cmd[i] = -LIM;
        for (int i = 0; i < NCH; i++) begin
            if (cmd[i] > LIM) cmd[i] = LIM;
            if (cmd[i] < -LIM) cmd[i] = -LIM;
            r.chan = i;
            r.cmd  = cmd[i];
            r.last = (i == NCH - 1);
            expected_cmds.push_back(r);
        end
        for (int i = 0; i < NRMP; i++) last_motor[i] = cmd[i];
    endtask

    task automatic predict_request();
        case (i_opcode)
            OP_SWEEP: begin
                if (!sweep_on && !motor_on && i_activate) begin
                    cap_chan = cfg_chan; cap_min = cfg_min; cap_max = cfg_max;
                    cap_step = cfg_step;
                    sweep_on = 1;
                    sweep_el = 0;
                end else if (!i_activate) begin
                    sweep_on = 0;
                end
            end
            OP_MOTOR: begin
                sweep_on = 0;
                if (!motor_on && i_activate) begin
                    foreach (ramp_from[i]) ramp_from[i] = last_motor[i];
                    ramp_to = motor_slider;
                    ramp_len = cfg_step;
                    motor_el = 0;
                    motor_on = 1;
                    for (int i = 0; i < NRMP; i++) sliders[i] = ramp_to;
                end
            end
            OP_SLIDER: if (i_channel < NCH) sliders[i_channel] = i_value;
            OP_MSLIDE: motor_slider = i_value;
            OP_TICK:   predict_tick(i_motors_master_on, i_motor_enable_mask);
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_cmd_result exp_r;
        if (!i_rst_n) begin
            clear_model();
            expected_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CHANNEL: cfg_chan = i_cfg_data[3:0];
                    REG_MIN:     cfg_min = $signed(i_cfg_data);
                    REG_MAX:     cfg_max = $signed(i_cfg_data);
                    REG_STEP:    cfg_step = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_ready) begin
                if (expected_cmds.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: chan %0d cmd %0d last %0d",
                                 i_out_channel, i_command, i_last);
                end else begin
                    exp_r = expected_cmds.pop_front();
                    if (exp_r.chan !== i_out_channel || exp_r.cmd !== i_command ||
                        exp_r.last !== i_last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp chan %0d cmd %0d last %0d, got %0d %0d %0d",
                                     exp_r.chan, exp_r.cmd, exp_r.last,
                                     i_out_channel, i_command, i_last);
                    end
                end
            end
            if (i_valid && i_in_ready) predict_request();
        end
        o_pending = expected_cmds.size();
    end
endmodule

### test/actuator_sweep_generator_tb.sv
module actuator_sweep_generator_tb
    import asg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               req_valid;
    logic               req_ready;
    logic [2:0]         opcode;
    logic               activate;
    logic [3:0]         channel;
    logic signed [15:0] value;
    logic               master_on;
    logic [4:0]         enable_mask;
    logic               cmd_valid;
    logic               cmd_ready;
    logic [3:0]         cmd_channel;
    logic signed [14:0] cmd_value;
    logic               cmd_last;
    int                 fail_count, pending;

    int  tx_idle, rx_idle;
    bit  hold_go, hold_done;
    int  hold_cnt;
    int  cycles;

    actuator_sweep_generator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_ready(req_ready),
        .i_opcode(opcode), .i_activate(activate), .i_channel(channel), .i_value(value),
        .i_motors_master_on(master_on), .i_motor_enable_mask(enable_mask),
        .o_valid(cmd_valid), .i_ready(cmd_ready),
        .o_out_channel(cmd_channel), .o_command(cmd_value), .o_last(cmd_last)
    );

    asg_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .i_in_ready(req_ready),
        .i_opcode(opcode), .i_activate(activate), .i_channel(channel), .i_value(value),
        .i_motors_master_on(master_on), .i_motor_enable_mask(enable_mask),
        .i_out_valid(cmd_valid), .i_ready(cmd_ready),
        .i_out_channel(cmd_channel), .i_command(cmd_value), .i_last(cmd_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ready <= 0;
        end else if (hold_cnt > 0) begin
            cmd_ready <= 0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_go && !hold_done) begin
            cmd_ready <= 0;
            hold_cnt <= 600;
            hold_done <= 1;
        end else begin
            cmd_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic send(logic [2:0] op, logic act, logic [3:0] ch, logic [15:0] val,
                        logic mon, logic [4:0] msk);
        if ($urandom_range(99) < tx_idle) begin
            req_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle) @(posedge i_clk);
        end
        req_valid <= 1;
        opcode <= op; activate <= act; channel <= ch; value <= val;
        master_on <= mon; enable_mask <= msk;
        do @(posedge i_clk); while (!req_ready);
    endtask

    task automatic tick(logic mon, logic [4:0] msk);
        send(OP_TICK, $urandom_range(1), $urandom_range(15), $urandom, mon, msk);
    endtask

    // waits for the block to drain, then writes all four registers
    task automatic configure(logic [3:0] ch, logic [15:0] lo, logic [15:0] hi,
                             logic [15:0] step);
        req_valid <= 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(posedge i_clk);
        cfg_we <= 1; cfg_index <= REG_CHANNEL; cfg_data <= ch;
        @(posedge i_clk);
        cfg_index <= REG_MIN; cfg_data <= lo;
        @(posedge i_clk);
        cfg_index <= REG_MAX; cfg_data <= hi;
        @(posedge i_clk);
        cfg_index <= REG_STEP; cfg_data <= step;
        @(posedge i_clk);
        cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_request(int unsigned sweep_ch);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 50)
            tick($urandom_range(9) != 0, ($urandom_range(3) == 0) ? $urandom : 5'h1F);
        else if (pick < 62)
            send(OP_SWEEP, $urandom_range(4) != 0, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 70)
            send(OP_MOTOR, $urandom_range(3) != 0, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 85)
            send(OP_SLIDER, $urandom, ($urandom_range(7) == 0) ? $urandom_range(15) : sweep_ch,
                 $urandom, $urandom, $urandom);
        else if (pick < 94)
            send(OP_MSLIDE, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            send($urandom_range(7, 5), $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        logic [3:0] sch;
        i_rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
        req_valid = 0; opcode = 0; activate = 0; channel = 0; value = 0;
        master_on = 0; enable_mask = 0;
        tx_idle = 33; rx_idle = 62;
        hold_go = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed part
        tick(0, 5'h1F);
        tick(1, 5'h00);
        send(OP_SLIDER, 0, 0, 16'sh7FFF, 0, 0);
        send(OP_SLIDER, 0, 10, 16'sh8000, 0, 0);
        send(OP_SLIDER, 0, 15, 16'sh1234, 0, 0);
        tick(1, 5'h1F);
        configure(10, 16'sh8000, 16'sh7FFF, 1);
        send(OP_SWEEP, 1, 0, 0, 0, 0);
        repeat (6) tick(1, 5'h15);
        send(OP_SWEEP, 1, 0, 0, 0, 0);
        send(OP_SWEEP, 0, 0, 0, 0, 0);
        tick(1, 5'h0A);
        send(OP_MSLIDE, 0, 0, 16'sd5000, 0, 0);
        send(OP_MOTOR, 1, 0, 0, 0, 0);
        send(OP_SWEEP, 1, 0, 0, 0, 0);
        send(OP_MOTOR, 1, 0, 0, 0, 0);
        repeat (3) tick(1, 5'h1F);
        send(3'd5, 1, 0, 0, 1, 5'h1F);
        send(3'd6, 1, 0, 0, 1, 5'h1F);
        send(3'd7, 1, 0, 0, 1, 5'h1F);
        configure(15, 16'sd100, 16'sd200, 0);
        send(OP_SWEEP, 1, 0, 0, 0, 0);
        repeat (3) tick(1, 5'h1F);

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            tx_idle = (ph < 2) ? 33 : (ph < 4) ? 62 : 0;
            rx_idle = (ph < 2) ? 62 : (ph < 4) ? 33 : 0;
            sch = (ph == 5) ? 4'd15 : $urandom_range(10);
            case (ph)
                1:       configure(0, 16'sh8000, 16'sh7FFF, 16'hFFFF);
                3:       configure(sch, 16'sh7FFF, 16'sh8000, 0);
                default: configure(sch, $urandom, $urandom, $urandom_range(6, 1));
            endcase
            if (ph == 4) hold_go <= 1;
            for (int n = 0; n < 25; n++) begin
                if ($urandom_range(2) == 0) begin
                    send(OP_SLIDER, $urandom, sch, $urandom, $urandom, $urandom);
                    send(OP_SWEEP, 1, $urandom, $urandom, $urandom, $urandom);
                end
                random_request(sch);
            end
        end

        req_valid <= 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
